### hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the sorted list engine
// Operation codes, status codes, and the control and link words that run
// along the row of list cells.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int KIND_WIDTH         = 3;
   localparam int STATUS_WIDTH       = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT       = 3'd0,
      KIND_REMOVE_FIRST = 3'd1,
      KIND_REMOVE_LAST  = 3'd2,
      KIND_REMOVE_VALUE = 3'd3,
      KIND_READ         = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_BAD_POS   = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic wr;        // cells load their next entry
      logic ins;       // sorted insert
      logic rm_first;  // every cell takes its right neighbor
      logic rm_value;  // cells at and after the first match take right neighbor
      logic desc;      // descending order for the insert compare
   } cell_ctl_type;

   // Prefix flags rippled from cell to cell, left to right
   typedef struct packed {
      logic here;   // insert point found at or left of this cell
      logic match;  // equal entry found at or left of this cell
   } link_type;

endpackage

### hdl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast value and shifts
// toward or away from its neighbors.
// ----------------------------------------------------------------------------
module sle_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEFAULT,
   parameter int POS_WIDTH  = 5
) (
   input  logic                         clock,
   input  sle_pkg::cell_ctl_type        ctl,
   input  logic signed [DATA_WIDTH-1:0] value,
   input  logic        [POS_WIDTH-1:0]  position,
   input  logic                         active,
   input  logic signed [DATA_WIDTH-1:0] prev_entry,
   input  logic signed [DATA_WIDTH-1:0] next_entry,
   input  sle_pkg::link_type            link_in,
   output sle_pkg::link_type            link_out,
   input  logic        [DATA_WIDTH-1:0] rd_in,
   output logic        [DATA_WIDTH-1:0] rd_out,
   output logic signed [DATA_WIDTH-1:0] entry
);

   logic signed [DATA_WIDTH-1:0] entry_ff;
   logic signed [DATA_WIDTH-1:0] entry_in;
   logic                         here;
   logic                         match;
   logic                         sel;

   // Cells past the fill point always claim the insert point
   assign here  = active ? (ctl.desc ? (entry_ff <= value) : (entry_ff >= value)) : 1'b1;
   assign match = active && (entry_ff == value);
   assign sel   = (position == POS_WIDTH'(INDEX + 1));

   assign link_out.here  = link_in.here | here;
   assign link_out.match = link_in.match | match;

   assign rd_out = rd_in | (sel ? entry_ff : '0);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (link_in.here) begin
            entry_in = prev_entry;
         end else if (here) begin
            entry_in = value;
         end
      end else if (ctl.rm_first) begin
         entry_in = next_entry;
      end else if (ctl.rm_value) begin
         if (link_out.match) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### hdl/sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_core: bounded sorted list with insert, remove and read
// A row of cells keeps signed entries in order; one operation word in, one
// result word out.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid req_stall req_kind req_value        | in
//          | req_position                                 |
//  result  | rsp_valid rsp_stall rsp_read_value rsp_status | out
//          | rsp_entry_count                              |
//  config  | csr_wr_en csr_wr_data (order_descending)      | in
//
//  Timing: a word is held in the operation register, then the whole
//    cell row updates and the result is registered; one word per cycle
//    sustained while rsp_stall is low. The clock period is set by the
//    cell row: compare in every cell, then the left-to-right prefix
//    ripple that picks the insert or remove point.
//  Reset: clears the count, the order bit and both valid flags. Entries are
//    left as they are; only slots below the count are ever read.
//  Stalls: rsp_stall holds the result register and, with it, the operation
//    register, which then stalls the request side.
//
module sorted_list_engine_core #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEFAULT,
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [sle_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic signed [DATA_WIDTH-1:0]         req_value,
   input  logic        [CW-1:0]                 req_position,
   // result
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [DATA_WIDTH-1:0]         rsp_read_value,
   output logic        [sle_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic        [CW-1:0]                 rsp_entry_count,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);

   // operation register
   logic                                 op_valid_ff, op_valid_in;
   logic        [sle_pkg::KIND_WIDTH-1:0] op_kind_ff;
   logic signed [DATA_WIDTH-1:0]         op_value_ff;
   logic        [CW-1:0]                 op_pos_ff;

   // list state
   logic [CW-1:0] count_ff, count_in;
   logic          order_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0]         rsp_read_value_ff, rsp_read_value_in;
   logic        [sle_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic        [CW-1:0]                 rsp_count_ff;

   logic accept;
   logic exec;
   logic empty;
   logic full;
   logic found;
   logic do_write;

   sle_pkg::cell_ctl_type ctl;
   sle_pkg::link_type     link [CAPACITY+1];
   logic [DATA_WIDTH-1:0] rd_chain [CAPACITY+1];
   logic signed [DATA_WIDTH-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   active;

   // ------------------------------------------------------------------
   // Handshake: the operation executes when the result register is free
   // or being drained this cycle; a new word may enter in the same cycle.
   // ------------------------------------------------------------------
   assign exec      = op_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = op_valid_ff && !exec;
   assign accept    = req_valid && !req_stall;

   assign op_valid_in  = accept ? 1'b1 : (exec ? 1'b0 : op_valid_ff);
   assign rsp_valid_in = exec ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CAPACITY));
   assign found = link[CAPACITY].match;

   // ------------------------------------------------------------------
   // Operation decode: status, read value, new count and the command for the cells
   // ------------------------------------------------------------------
   always_comb begin
      count_in          = count_ff;
      rsp_status_in     = sle_pkg::STATUS_OK;
      rsp_read_value_in = '0;
      do_write          = 1'b0;
      ctl               = '0;
      ctl.desc          = order_ff;
      unique case (op_kind_ff)
         sle_pkg::KIND_INSERT: begin
            if (full) begin
               rsp_status_in = sle_pkg::STATUS_FULL;
            end else begin
               ctl.ins  = 1'b1;
               do_write = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         sle_pkg::KIND_REMOVE_FIRST: begin
            if (empty) begin
               rsp_status_in = sle_pkg::STATUS_EMPTY;
            end else begin
               ctl.rm_first = 1'b1;
               do_write     = 1'b1;
               count_in     = count_ff - CW'(1);
            end
         end
         sle_pkg::KIND_REMOVE_LAST: begin
            // last slot simply falls out of range
            if (empty) begin
               rsp_status_in = sle_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         sle_pkg::KIND_REMOVE_VALUE: begin
            if (empty) begin
               rsp_status_in = sle_pkg::STATUS_EMPTY;
            end else begin
               // with no match no cell shifts, so the write is harmless
               ctl.rm_value = 1'b1;
               do_write     = 1'b1;
               if (found) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  rsp_status_in = sle_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         sle_pkg::KIND_READ: begin
            if (op_pos_ff == '0 || op_pos_ff > count_ff) begin
               rsp_status_in = sle_pkg::STATUS_BAD_POS;
            end else begin
               rsp_read_value_in = rd_chain[CAPACITY];
            end
         end
         default: begin
            // unused kinds: no change, status ok
         end
      endcase
      ctl.wr = exec && do_write;
   end

   // ------------------------------------------------------------------
   // Cell row: link and read chains run left to right
   // ------------------------------------------------------------------
   assign link[0]     = '0;
   assign rd_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] prev_entry;
      logic signed [DATA_WIDTH-1:0] next_entry;

      assign active[i]  = (count_ff > CW'(i));
      assign prev_entry = (i == 0) ? '0 : cell_entry[(i == 0) ? 0 : i - 1];
      assign next_entry = (i == CAPACITY - 1) ? '0
                          : cell_entry[(i == CAPACITY - 1) ? i : i + 1];

      sle_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .POS_WIDTH  (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .value      (op_value_ff),
         .position   (op_pos_ff),
         .active     (active[i]),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .rd_in      (rd_chain[i]),
         .rd_out     (rd_chain[i+1]),
         .entry      (cell_entry[i])
      );
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         order_ff     <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff  <= req_kind;
         op_value_ff <= req_value;
         op_pos_ff   <= req_position;
      end
      if (exec) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid && (rsp_entry_count == count_ff))
      else $error("result count differs from list count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sle_pkg::STATUS_FULL) |-> rsp_entry_count == CW'(CAPACITY))
      else $error("full status with room left");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sle_pkg::STATUS_OK) |-> rsp_read_value == '0)
      else $error("read value set on failed operation");

endmodule
